@@ hdl/xml_text_escaper_top_assert.svh @@
`ifndef XML_TEXT_ESCAPER_TOP_ASSERT_SVH
`define XML_TEXT_ESCAPER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define XTE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("xte check failed");

// next-cycle implication, disabled while in reset
`define XTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("xte check failed");

`endif

@@ hdl/xte_pkg.sv @@
package xte_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    K_PLAIN,
    K_AMP,
    K_LT,
    K_GT,
    K_APOS,
    K_QUOT,
    K_NUM
  } kind_t;

  // data holds the raw byte for plain, or {2'b0, tens, ones} for a numeric reference
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } tok_t;

  function automatic tok_t classify(input logic [7:0] b);
    tok_t       t;
    logic [4:0] v;
    logic [4:0] ones;
    logic [1:0] tens;
    v    = b[4:0];
    tens = 2'd0;
    ones = v;
    if (v >= 5'd30) begin
      tens = 2'd3;
      ones = v - 5'd30;
    end else if (v >= 5'd20) begin
      tens = 2'd2;
      ones = v - 5'd20;
    end else if (v >= 5'd10) begin
      tens = 2'd1;
      ones = v - 5'd10;
    end
    t.kind = K_PLAIN;
    t.data = b;
    case (b)
      8'h26: t.kind = K_AMP;
      8'h3c: t.kind = K_LT;
      8'h3e: t.kind = K_GT;
      8'h27: t.kind = K_APOS;
      8'h22: t.kind = K_QUOT;
      default: begin
        if (b inside {8'h20, 8'h09, 8'h0d, 8'h0a}) begin
          t.kind = K_PLAIN;
        end else if (b < 8'h20) begin
          t.kind = K_NUM;
          t.data = {2'b00, tens, ones[3:0]};
        end
      end
    endcase
    return t;
  endfunction

  function automatic logic [2:0] seq_len(input kind_t k);
    logic [2:0] n;
    case (k)
      K_PLAIN: n = 3'd1;
      K_AMP:   n = 3'd5;
      K_LT:    n = 3'd4;
      K_GT:    n = 3'd4;
      K_APOS:  n = 3'd6;
      K_QUOT:  n = 3'd6;
      K_NUM:   n = 3'd5;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] seq_byte(input tok_t t, input logic [2:0] idx);
    logic [7:0] r;
    r = 8'h3b;
    if (idx == 3'd0) begin
      r = 8'h26;
    end
    case (t.kind)
      K_PLAIN: r = t.data;
      K_AMP: begin
        case (idx)
          3'd1: r = 8'h61;
          3'd2: r = 8'h6d;
          3'd3: r = 8'h70;
          default: ;
        endcase
      end
      K_LT: begin
        case (idx)
          3'd1: r = 8'h6c;
          3'd2: r = 8'h74;
          default: ;
        endcase
      end
      K_GT: begin
        case (idx)
          3'd1: r = 8'h67;
          3'd2: r = 8'h74;
          default: ;
        endcase
      end
      K_APOS: begin
        case (idx)
          3'd1: r = 8'h61;
          3'd2: r = 8'h70;
          3'd3: r = 8'h6f;
          3'd4: r = 8'h73;
          default: ;
        endcase
      end
      K_QUOT: begin
        case (idx)
          3'd1: r = 8'h71;
          3'd2: r = 8'h75;
          3'd3: r = 8'h6f;
          3'd4: r = 8'h74;
          default: ;
        endcase
      end
      K_NUM: begin
        case (idx)
          3'd1: r = 8'h23;
          3'd2: r = {6'b001100, t.data[5:4]};
          3'd3: r = {4'b0011, t.data[3:0]};
          default: ;
        endcase
      end
      default: r = t.data;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/xml_text_escaper_top.sv @@
// XML text escaper: one text byte in per transfer, its escaped form out one byte per
// transfer with last set on the final byte. The block sustains one byte per cycle on a
// stream of plain bytes while out_ready holds. An escaped byte (&, <, >, ', ", or a
// control byte other than tab, CR and LF) produces 4 to 6 output bytes, one per cycle
// while out_ready holds, set by the back-end sequencer that walks each entry of the token
// queue; while it does, input keeps being accepted until the queue (QDEPTH entries)
// fills. An accepted byte passes through the token queue, then the output register.
module xml_text_escaper_top
  import xte_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last
);

  logic q_full;
  logic q_push;
  tok_t q_tok;
  logic q_empty;
  logic q_pop;
  tok_t q_head;

  xte_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (q_tok)
  );

  xte_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_tok (q_tok),
    .full   (q_full),
    .pop    (q_pop),
    .head   (q_head),
    .empty  (q_empty)
  );

  xte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

@@ hdl/xte_fifo.sv @@
module xte_fifo
  import xte_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t wr_tok,
  output logic full,
  input  logic pop,
  output tok_t head,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/xte_front.sv @@
module xte_front
  import xte_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_full,
  output logic       q_push,
  output tok_t       q_tok
);

  // one queue entry per accepted byte, already sorted into its escape kind
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_tok    = classify(in_byte);

endmodule

@@ hdl/xte_back.sv @@
module xte_back
  import xte_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  tok_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last
);

  logic [2:0] idx;
  logic [2:0] idx_next;
  logic       load;
  logic       at_end;

  // output register may take a new byte when empty or being drained
  assign load     = !q_empty && (!out_valid || out_ready);
  assign at_end   = (idx == seq_len(q_head.kind) - 3'd1);
  assign q_pop    = load && at_end;
  assign idx_next = at_end ? 3'd0 : idx + 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= idx_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= seq_byte(q_head, idx);
      last     <= at_end;
    end
  end

endmodule

@@ hdl/xte_checker.sv @@
`include "xml_text_escaper_top_assert.svh"

module xte_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last
);

  // stalled input holds
  `XTE_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid && $stable(in_byte))
  // stalled output holds
  `XTE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_byte) && $stable(last))
  // an expansion continues without a gap
  `XTE_ASSERT_NEXT(a_no_gap, clk, rst, out_valid && out_ready && !last, out_valid)
  // ampersand only ever opens an escape
  `XTE_ASSERT_NOW(a_amp_open, clk, rst, out_valid && out_byte == 8'h26, !last)
  // semicolon inside an escape only closes it
  `XTE_ASSERT_NOW(a_semi_close, clk, rst, out_valid && !last, out_byte != 8'h3b)

endmodule

bind xml_text_escaper_top xte_checker u_xte_checker (.*);

@@ bench/testbench.sv @@
module testbench;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;

  typedef struct packed {
    logic [7:0] chr;
    logic       fin;
  } esc_char_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last;

  esc_char_t escaped_q[$];
  int        errors          = 0;
  int        bytes_sent      = 0;
  int        escapes_sent    = 0;
  int        chars_checked   = 0;
  int        cycle_cnt       = 0;
  int        in_stall_cycles = 0;
  int        send_idle_pct   = 0;
  int        recv_idle_pct   = 0;
  int        hold_left       = 0;

  xml_text_escaper_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected escaped form of one text byte, appended to the queue
  function automatic void push_escaped(input logic [7:0] b);
    string     seq;
    esc_char_t c;
    case (b)
      CH_AMP:  seq = "&amp;";
      CH_LT:   seq = "&lt;";
      CH_GT:   seq = "&gt;";
      CH_APOS: seq = "&apos;";
      CH_QUOT: seq = "&quot;";
      CH_SPACE, CH_TAB, CH_CR, CH_LF: seq = "";
      default: seq = (b < CH_SPACE) ? $sformatf("&#%02d;", int'(b)) : "";
    endcase
    if (seq.len() == 0) begin
      c.chr = b;
      c.fin = 1'b1;
      escaped_q.push_back(c);
    end else begin
      escapes_sent++;
      for (int k = 0; k < seq.len(); k++) begin
        c.chr = seq[k];
        c.fin = (k == seq.len() - 1);
        escaped_q.push_back(c);
      end
    end
  endfunction

  // text mix: markup characters, control bytes and anything else
  function automatic logic [7:0] rand_text_byte();
    logic [7:0] markup [5] = '{CH_AMP, CH_LT, CH_GT, CH_APOS, CH_QUOT};
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return markup[$urandom_range(0, 4)];
    if (pick < 5) return 8'($urandom_range(1, 31));
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic send_char(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    push_escaped(b);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [7:0] corner [22] = '{
      8'h00, 8'h01, CH_TAB, CH_LF, CH_CR, CH_SPACE, 8'h1f, 8'h13, 8'h0b,
      CH_AMP, CH_LT, CH_GT, CH_APOS, CH_QUOT,
      8'h21, 8'h7f, 8'h80, 8'hff, 8'h55, 8'haa, 8'h3d, 8'h41
    };
    send_idle_pct = 30;
    recv_idle_pct = 30;
    foreach (corner[i]) send_char(corner[i]);
    wait_drain();
  endtask

  task automatic test_text_phase(input int n, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) send_char(rand_text_byte());
    wait_drain();
  endtask

  // sink stops for a long stretch while the source keeps pushing
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left <= HOLD_CYCLES;
    repeat (40) send_char(rand_text_byte());
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    esc_char_t want;
    if (!rst && out_valid && out_ready) begin
      chars_checked++;
      if (escaped_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte 8'h%02h last %0b", out_byte, last));
      end else begin
        want = escaped_q.pop_front();
        if (out_byte !== want.chr)
          report_mismatch($sformatf("out_byte 8'h%02h, want 8'h%02h", out_byte, want.chr));
        if (last !== want.fin)
          report_mismatch($sformatf("last %0b, want %0b (byte 8'h%02h)", last, want.fin,
                                    want.chr));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (in_valid && !in_ready) in_stall_cycles++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
               escaped_q.size());
      $display("** xml_text_escaper_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_text_phase(130, 19, 74);
    test_output_hold();
    test_text_phase(130, 74, 19);
    test_text_phase(130, 0, 0);
    $display("%0d text bytes sent, %0d of them escaped, %0d output bytes checked",
             bytes_sent, escapes_sent, chars_checked);
    $display("slow sink, slow source and full rate mixes; input stalled %0d cycles",
             in_stall_cycles);
    if (errors == 0) begin
      $display("** xml_text_escaper_top: PASSED **");
    end else begin
      $display("** xml_text_escaper_top: FAILED **");
    end
    $finish;
  end

endmodule
